FILE: design/cfrf_pkg.sv
// Shared types and constants for the command frame receive FIFO.
package cfrf_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int MAX_DRAIN = 15;
  localparam int DRAIN_CNT_W = 4;
  localparam int LEN_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  localparam logic [7:0] CH_P = 8'h70;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_N = 8'h6e;

  localparam logic [LEN_W-1:0] LEN_P = 3'd3;
  localparam logic [LEN_W-1:0] LEN_B = 3'd4;
  localparam logic [LEN_W-1:0] LEN_E = 3'd1;
  localparam logic [LEN_W-1:0] LEN_N = 3'd1;
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic INITIAL_PHASE_RST = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       frame_ready;
    logic       last;
  } out_req_t;

  typedef struct packed {
    logic             drain;
    logic [7:0]       data;
    logic             force_one;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

FILE: design/cfrf_front.sv
// Front end: holds the phase register and classifies incoming requests.
module cfrf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  cfrf_pkg::in_req_t in_data,
  output cfrf_pkg::cmd_t   cmd
);

  logic initial_phase_r;
  logic initial_phase_nxt;

  always_comb begin
    initial_phase_nxt = initial_phase_r;
    if (cfg_wr_en) begin
      initial_phase_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_phase_r <= cfrf_pkg::INITIAL_PHASE_RST;
    end else begin
      initial_phase_r <= initial_phase_nxt;
    end
  end

  always_comb begin
    cmd.drain = (in_data.operation == cfrf_pkg::OP_DRAIN);
    cmd.data = in_data.rx_byte;
    cmd.force_one = initial_phase_r && (in_data.rx_byte == cfrf_pkg::CH_B);
    case (in_data.rx_byte)
      cfrf_pkg::CH_P: cmd.len = cfrf_pkg::LEN_P;
      cfrf_pkg::CH_B: cmd.len = cfrf_pkg::LEN_B;
      cfrf_pkg::CH_E: cmd.len = cfrf_pkg::LEN_E;
      cfrf_pkg::CH_N: cmd.len = cfrf_pkg::LEN_N;
      default: cmd.len = cfrf_pkg::LEN_NONE;
    endcase
  end

endmodule

FILE: design/cfrf_queue.sv
// Two-entry command queue between the front end and the back end.
module cfrf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cfrf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output cfrf_pkg::cmd_t pop_cmd
);

  cfrf_pkg::cmd_t entry_r [cfrf_pkg::QUEUE_DEPTH];
  logic [cfrf_pkg::QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [cfrf_pkg::QUEUE_PTR_W-1:0] wr_ptr_nxt;
  logic [cfrf_pkg::QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [cfrf_pkg::QUEUE_PTR_W-1:0] rd_ptr_nxt;
  logic [cfrf_pkg::QUEUE_CNT_W-1:0] count_r;
  logic [cfrf_pkg::QUEUE_CNT_W-1:0] count_nxt;

  assign full = (count_r == cfrf_pkg::QUEUE_CNT_W'(cfrf_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/cfrf_back.sv
// Back end: frame assembly, ring buffer storage, drain sequencer and output register.
module cfrf_back #(
  parameter int FIFO_DEPTH = cfrf_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cfrf_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  output cfrf_pkg::out_req_t out_data,
  input  logic               out_stall
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CMP_W = (PTR_W + 1 > cfrf_pkg::DRAIN_CNT_W) ? PTR_W + 1
                                                              : cfrf_pkg::DRAIN_CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] i);
    next_idx = (i == PTR_W'(FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [7:0] mem [FIFO_DEPTH];
  logic [7:0] rd_data_r;

  state_t state_r;
  state_t state_nxt;
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_r;
  logic [PTR_W-1:0] tail_nxt;
  logic [cfrf_pkg::LEN_W-1:0] awaited_r;
  logic [cfrf_pkg::LEN_W-1:0] awaited_nxt;
  logic ready_r;
  logic ready_nxt;
  logic [cfrf_pkg::DRAIN_CNT_W-1:0] remaining_r;
  logic [cfrf_pkg::DRAIN_CNT_W-1:0] remaining_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  cfrf_pkg::out_req_t out_data_r;
  cfrf_pkg::out_req_t out_data_nxt;

  logic mem_we;
  logic out_free;
  logic full;
  logic [CMP_W-1:0] count;
  logic [CMP_W-1:0] drain_n;

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign out_free = !out_valid_r || !out_stall;
  assign full = (next_idx(tail_r) == head_r);

  always_comb begin
    if (tail_r >= head_r) begin
      count = CMP_W'(tail_r - head_r);
    end else begin
      count = CMP_W'({1'b0, tail_r} + (PTR_W + 1)'(FIFO_DEPTH) - {1'b0, head_r});
    end
    drain_n = (count > CMP_W'(cfrf_pkg::MAX_DRAIN)) ? CMP_W'(cfrf_pkg::MAX_DRAIN) : count;
  end

  always_comb begin
    logic take;
    logic [cfrf_pkg::LEN_W-1:0] awaited_v;
    logic [cfrf_pkg::LEN_W-1:0] awaited_dec;
    take = 1'b0;
    awaited_v = awaited_r;
    awaited_dec = awaited_r;
    state_nxt = state_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    awaited_nxt = awaited_r;
    ready_nxt = ready_r;
    remaining_nxt = remaining_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    mem_we = 1'b0;
    q_pop = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (!q_cmd.drain) begin
            if (!ready_r) begin
              take = 1'b1;
              if (q_cmd.force_one) begin
                awaited_v = cfrf_pkg::LEN_W'(1);
              end else if (awaited_r == '0) begin
                if (q_cmd.len == cfrf_pkg::LEN_NONE) begin
                  take = 1'b0;
                end else begin
                  awaited_v = q_cmd.len;
                end
              end
            end
            if (take) begin
              if (!full) begin
                mem_we = 1'b1;
                tail_nxt = next_idx(tail_r);
              end
              awaited_dec = awaited_v - 1'b1;
              awaited_nxt = awaited_dec;
              if (awaited_dec == '0) begin
                ready_nxt = 1'b1;
              end
            end
            out_valid_nxt = 1'b1;
            out_data_nxt = '{byte_valid: 1'b0, out_byte: 8'h00,
                             frame_ready: ready_nxt, last: 1'b1};
          end else if (count == '0) begin
            ready_nxt = 1'b0;
            out_valid_nxt = 1'b1;
            out_data_nxt = '{byte_valid: 1'b0, out_byte: 8'h00,
                             frame_ready: 1'b0, last: 1'b1};
          end else begin
            remaining_nxt = drain_n[cfrf_pkg::DRAIN_CNT_W-1:0];
            if (count <= CMP_W'(cfrf_pkg::MAX_DRAIN)) begin
              ready_nxt = 1'b0;
            end
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '{byte_valid: 1'b1, out_byte: rd_data_r, frame_ready: ready_r,
                           last: (remaining_r == cfrf_pkg::DRAIN_CNT_W'(1))};
          head_nxt = next_idx(head_r);
          remaining_nxt = remaining_r - 1'b1;
          state_nxt = (remaining_r == cfrf_pkg::DRAIN_CNT_W'(1)) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r <= '0;
      tail_r <= '0;
      awaited_r <= '0;
      ready_r <= 1'b0;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      awaited_r <= awaited_nxt;
      ready_r <= ready_nxt;
      remaining_r <= remaining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= q_cmd.data;
    end
    rd_data_r <= mem[head_r];
  end

endmodule

FILE: design/command_frame_receive_fifo_core.sv
// Command frame receive FIFO: top level joining front end, command queue and back end.
// A received-byte request gives a single result, passing through the queue and the output register.
// A drain gives stored bytes one at a time, each through the registered ring buffer
// read (ST_RD then ST_OUT), at most 15 bytes; an empty drain gives one result.
// Requests are taken one per cycle, unless the queue is full, into a two-entry queue while the back end works.
// Synchronous active-low reset empties the queue and ring and sets the initial phase.
module command_frame_receive_fifo_core #(
  parameter int FIFO_DEPTH = cfrf_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfrf_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cfrf_pkg::out_req_t out_data
);

  cfrf_pkg::cmd_t front_cmd;
  cfrf_pkg::cmd_t q_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign in_stall = q_full;

  cfrf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (front_cmd)
  );

  cfrf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  cfrf_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
